### design/csrel_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// csrel_pkg
// Shared types and constants of the compressed-row element lookup unit.
// ----------------------------------------------------------------------------
package csrel_pkg;

    localparam int MAX_ROWS_DEF = 256;
    localparam int MAX_NNZ_DEF  = 4096;

    localparam int RSW     = 13;   // row-start value width
    localparam int COLW    = 9;    // stored column width
    localparam int IDXW    = 9;    // query index width
    localparam int SLOTW   = 12;
    localparam int CFG_AW  = 5;
    localparam int CFG_DW  = 32;
    localparam int NUM_REGS = 8;

    localparam logic [1:0] OP_LOAD_ROW   = 2'd0;
    localparam logic [1:0] OP_LOAD_ENTRY = 2'd1;
    localparam logic [1:0] OP_QUERY      = 2'd2;

    localparam logic [2:0] REG_INDEX_BASE   = 3'd0;
    localparam logic [2:0] REG_UNIT_DIAG    = 3'd1;
    localparam logic [2:0] REG_TRI_UPPER    = 3'd2;
    localparam logic [2:0] REG_TRI_LOWER    = 3'd3;
    localparam logic [2:0] REG_SYMMETRIC    = 3'd4;
    localparam logic [2:0] REG_HERMITIAN    = 3'd5;
    localparam logic [2:0] REG_STORED_UPPER = 3'd6;
    localparam logic [2:0] REG_STORED_LOWER = 3'd7;

    localparam logic [31:0] Q_ONE   = 32'h0001_0000;
    localparam logic [31:0] SAT_MAX = 32'h7FFF_FFFF;
    localparam logic [31:0] SAT_MIN = 32'h8000_0000;

    typedef struct packed {
        logic [1:0]        operation;
        logic [SLOTW-1:0]  slot;
        logic [RSW-1:0]    row_start_value;
        logic [COLW-1:0]   stored_column;
        logic signed [31:0] load_re;
        logic signed [31:0] load_im;
        logic [IDXW-1:0]   query_row;
        logic [IDXW-1:0]   query_col;
    } req_t;

    typedef struct packed {
        logic signed [31:0] value_re;
        logic signed [31:0] value_im;
        logic               out_of_range;
    } rsp_t;

    typedef struct packed {
        logic index_base;
        logic unit_diag_implicit;
        logic tri_upper;
        logic tri_lower;
        logic symmetric;
        logic hermitian;
        logic stored_upper;
        logic stored_lower;
    } cfg_t;

    typedef struct packed {
        logic [COLW-1:0]    col;
        logic signed [31:0] im;
        logic signed [31:0] re;
    } entry_t;

endpackage
`default_nettype wire

### design/csrel_cfg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// csrel_cfg
// APB register file holding the eight one-bit matrix pattern registers.
// ----------------------------------------------------------------------------
module csrel_cfg
(
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           psel,
    input  wire logic                           penable,
    input  wire logic                           pwrite,
    input  wire logic [csrel_pkg::CFG_AW-1:0]   paddr,
    input  wire logic [csrel_pkg::CFG_DW-1:0]   pwdata,
    output logic      [csrel_pkg::CFG_DW-1:0]   prdata,
    output logic                                pready,
    output csrel_pkg::cfg_t                     cfg
);

    logic [csrel_pkg::NUM_REGS-1:0] cfg_reg;
    logic [2:0]                     idx;

    assign idx    = paddr[csrel_pkg::CFG_AW-1:2];
    assign pready = 1'b1;
    assign prdata = {{(csrel_pkg::CFG_DW-1){1'b0}}, cfg_reg[idx]};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= '0;
        end
        else if (psel && penable && pwrite)
        begin
            cfg_reg[idx] <= pwdata[0];
        end
    end

    always_comb
    begin
        cfg.index_base         = cfg_reg[csrel_pkg::REG_INDEX_BASE];
        cfg.unit_diag_implicit = cfg_reg[csrel_pkg::REG_UNIT_DIAG];
        cfg.tri_upper          = cfg_reg[csrel_pkg::REG_TRI_UPPER];
        cfg.tri_lower          = cfg_reg[csrel_pkg::REG_TRI_LOWER];
        cfg.symmetric          = cfg_reg[csrel_pkg::REG_SYMMETRIC];
        cfg.hermitian          = cfg_reg[csrel_pkg::REG_HERMITIAN];
        cfg.stored_upper       = cfg_reg[csrel_pkg::REG_STORED_UPPER];
        cfg.stored_lower       = cfg_reg[csrel_pkg::REG_STORED_LOWER];
    end

endmodule
`default_nettype wire

### design/csrel_row_mem.sv
`default_nettype none
// ----------------------------------------------------------------------------
// csrel_row_mem
// Row-start table: one write port, one registered read port.
// ----------------------------------------------------------------------------
module csrel_row_mem
#(
    parameter int MAX_ROWS = csrel_pkg::MAX_ROWS_DEF,
    localparam int RAW = $clog2(MAX_ROWS + 1)
)
(
    input  wire logic                        clk,
    input  wire logic                        wr_en,
    input  wire logic [RAW-1:0]              wr_addr,
    input  wire logic [csrel_pkg::RSW-1:0]   wr_data,
    input  wire logic                        rd_en,
    input  wire logic [RAW-1:0]              rd_addr,
    output logic      [csrel_pkg::RSW-1:0]   rd_data
);

    logic [csrel_pkg::RSW-1:0] mem [MAX_ROWS+1];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule
`default_nettype wire

### design/csrel_entry_mem.sv
`default_nettype none
// ----------------------------------------------------------------------------
// csrel_entry_mem
// Nonzero store: column index and complex value per entry, registered read.
// ----------------------------------------------------------------------------
module csrel_entry_mem
#(
    parameter int MAX_NNZ = csrel_pkg::MAX_NNZ_DEF,
    localparam int AW = (MAX_NNZ > 1) ? $clog2(MAX_NNZ) : 1
)
(
    input  wire logic              clk,
    input  wire logic              wr_en,
    input  wire logic [AW-1:0]     wr_addr,
    input  wire csrel_pkg::entry_t wr_data,
    input  wire logic              rd_en,
    input  wire logic [AW-1:0]     rd_addr,
    output csrel_pkg::entry_t      rd_data
);

    csrel_pkg::entry_t mem [MAX_NNZ];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule
`default_nettype wire

### design/csr_entry_lookup_unit.sv
`default_nettype none
// ----------------------------------------------------------------------------
// csr_entry_lookup_unit
// Element lookup in a compressed-row sparse matrix with complex Q16.16 values.
// ----------------------------------------------------------------------------
// Load items write the row-start table or one nonzero entry. A query reads
// the two row bounds from the row-start memory in states RD0, RD1 and RD2,
// then scans the row one stored entry per cycle through the entry memory's
// single read port, adds matching entries in a wide accumulator and
// saturates at the end. Out-of-range queries, the implicit unit diagonal
// and positions outside a triangular pattern go straight to the finish
// state. The result sits in an output register, so load items are taken
// while a result waits; a query waits in its finish state until the
// register is free.
// ----------------------------------------------------------------------------
module csr_entry_lookup_unit
#(
    parameter int MAX_ROWS = csrel_pkg::MAX_ROWS_DEF,
    parameter int MAX_NNZ  = csrel_pkg::MAX_NNZ_DEF
)
(
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           req_valid,
    output logic                                req_ready,
    input  wire csrel_pkg::req_t                req,
    output logic                                rsp_valid,
    input  wire logic                           rsp_ready,
    output csrel_pkg::rsp_t                     rsp,
    input  wire logic                           psel,
    input  wire logic                           penable,
    input  wire logic                           pwrite,
    input  wire logic [csrel_pkg::CFG_AW-1:0]   paddr,
    input  wire logic [csrel_pkg::CFG_DW-1:0]   pwdata,
    output logic      [csrel_pkg::CFG_DW-1:0]   prdata,
    output logic                                pready
);

    localparam int RAW = $clog2(MAX_ROWS + 1);
    localparam int AW  = (MAX_NNZ > 1) ? $clog2(MAX_NNZ) : 1;
    localparam int NCW = $clog2(MAX_NNZ + 1);
    localparam int KW  = (NCW > csrel_pkg::RSW) ? NCW : csrel_pkg::RSW;
    localparam int SW  = 32 + NCW + 1;
    localparam int IW  = csrel_pkg::IDXW;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_RD0,
        ST_RD1,
        ST_RD2,
        ST_SCAN,
        ST_FINISH
    } state_t;

    csrel_pkg::cfg_t   cfg;
    csrel_pkg::entry_t ent_wr;
    csrel_pkg::entry_t ent_rd;
    csrel_pkg::rsp_t   rsp_reg, rsp_next;

    state_t              state_reg, state_next;
    logic [IW-1:0]       i0_reg, i0_next;
    logic [IW-1:0]       j0_reg, j0_next;
    logic                neg_reg, neg_next;
    logic                oor_reg, oor_next;
    logic [KW-1:0]       k_reg, k_next;
    logic [KW-1:0]       end_reg, end_next;
    logic                rd_vld_reg, rd_vld_next;
    logic signed [SW-1:0] sre_reg, sre_next;
    logic signed [SW-1:0] sim_reg, sim_next;
    logic                rsp_valid_reg, rsp_valid_next;

    logic                accept;
    logic [31:0]         slot_w;
    logic [31:0]         row_w;
    logic [31:0]         col_w;
    logic                row_wr_en;
    logic                ent_wr_en;
    logic                row_rd_en;
    logic [RAW-1:0]      row_rd_addr;
    logic [csrel_pkg::RSW-1:0] row_rd_data;
    logic [31:0]         i0_w;
    logic [31:0]         i0m1_w;
    logic                ent_rd_en;
    logic [KW-1:0]       rs_k;
    logic [KW-1:0]       base_k;
    logic [KW-1:0]       rs_sub;
    logic                rs_neg;
    logic [IW:0]         ent_col;
    logic                col_hit;
    logic signed [SW-1:0] sim_fin;
    logic                q_oor;
    logic                q_diag;
    logic                q_zero;
    logic                q_trans;

    assign accept    = req_valid && req_ready;
    assign req_ready = (state_reg == ST_IDLE);
    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    assign slot_w = 32'(req.slot);
    assign row_w  = 32'(req.query_row);
    assign col_w  = 32'(req.query_col);

    assign row_wr_en = accept && (req.operation == csrel_pkg::OP_LOAD_ROW)
                       && (slot_w <= 32'(MAX_ROWS));
    assign ent_wr_en = accept && (req.operation == csrel_pkg::OP_LOAD_ENTRY)
                       && (slot_w < 32'(MAX_NNZ));
    assign ent_wr.col = req.stored_column;
    assign ent_wr.re  = req.load_re;
    assign ent_wr.im  = req.load_im;

    assign i0_w   = 32'(i0_reg);
    assign i0m1_w = i0_w - 32'd1;

    assign row_rd_en   = (state_reg == ST_RD0) || (state_reg == ST_RD1);
    assign row_rd_addr = (state_reg == ST_RD0) ? i0m1_w[RAW-1:0] : i0_w[RAW-1:0];

    assign ent_rd_en = (state_reg == ST_SCAN) && (k_reg < end_reg);

    assign rs_k   = KW'(row_rd_data);
    assign base_k = KW'(cfg.index_base);
    assign rs_neg = (rs_k < base_k);
    assign rs_sub = rs_k - base_k;

    assign ent_col = {1'b0, ent_rd.col} + (IW+1)'(1) - (IW+1)'(cfg.index_base);
    assign col_hit = (ent_col == {1'b0, j0_reg});

    assign q_oor  = (row_w < 32'd1) || (row_w > 32'(MAX_ROWS))
                    || (col_w < 32'd1) || (col_w > 32'(MAX_ROWS));
    assign q_diag = (req.query_row == req.query_col) && cfg.unit_diag_implicit;
    assign q_zero = (cfg.tri_upper && (req.query_col < req.query_row))
                    || (cfg.tri_lower && (req.query_col > req.query_row));
    assign q_trans = (cfg.symmetric || cfg.hermitian)
                     && (cfg.stored_upper != cfg.stored_lower)
                     && ((cfg.stored_upper && (req.query_col < req.query_row))
                         || (cfg.stored_lower && (req.query_col > req.query_row)));

    assign sim_fin = neg_reg ? -sim_reg : sim_reg;

    csrel_cfg u_cfg
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    csrel_row_mem #(.MAX_ROWS(MAX_ROWS)) u_row_mem
    (
        .clk     (clk),
        .wr_en   (row_wr_en),
        .wr_addr (slot_w[RAW-1:0]),
        .wr_data (req.row_start_value),
        .rd_en   (row_rd_en),
        .rd_addr (row_rd_addr),
        .rd_data (row_rd_data)
    );

    csrel_entry_mem #(.MAX_NNZ(MAX_NNZ)) u_entry_mem
    (
        .clk     (clk),
        .wr_en   (ent_wr_en),
        .wr_addr (slot_w[AW-1:0]),
        .wr_data (ent_wr),
        .rd_en   (ent_rd_en),
        .rd_addr (k_reg[AW-1:0]),
        .rd_data (ent_rd)
    );

    always_comb
    begin
        state_next     = state_reg;
        i0_next        = i0_reg;
        j0_next        = j0_reg;
        neg_next       = neg_reg;
        oor_next       = oor_reg;
        k_next         = k_reg;
        end_next       = end_reg;
        rd_vld_next    = 1'b0;
        sre_next       = sre_reg;
        sim_next       = sim_reg;
        rsp_next       = rsp_reg;
        rsp_valid_next = rsp_valid_reg && !rsp_ready;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept && (req.operation == csrel_pkg::OP_QUERY))
                begin
                    sre_next = '0;
                    sim_next = '0;
                    neg_next = 1'b0;
                    oor_next = q_oor;
                    i0_next  = q_trans ? req.query_col : req.query_row;
                    j0_next  = q_trans ? req.query_row : req.query_col;
                    if (q_oor || q_zero)
                    begin
                        state_next = ST_FINISH;
                    end
                    else if (q_diag)
                    begin
                        sre_next   = SW'(csrel_pkg::Q_ONE);
                        state_next = ST_FINISH;
                    end
                    else
                    begin
                        neg_next   = q_trans && cfg.hermitian;
                        state_next = ST_RD0;
                    end
                end
            end
            ST_RD0:
            begin
                state_next = ST_RD1;
            end
            ST_RD1:
            begin
                k_next     = rs_neg ? '0 : rs_sub;
                state_next = ST_RD2;
            end
            ST_RD2:
            begin
                if (rs_neg)
                begin
                    end_next = '0;
                end
                else if (rs_sub > KW'(MAX_NNZ))
                begin
                    end_next = KW'(MAX_NNZ);
                end
                else
                begin
                    end_next = rs_sub;
                end
                state_next = ST_SCAN;
            end
            ST_SCAN:
            begin
                if (ent_rd_en)
                begin
                    k_next      = k_reg + KW'(1);
                    rd_vld_next = 1'b1;
                end
                if (rd_vld_reg && col_hit)
                begin
                    sre_next = sre_reg + {{(SW-32){ent_rd.re[31]}}, ent_rd.re};
                    sim_next = sim_reg + {{(SW-32){ent_rd.im[31]}}, ent_rd.im};
                end
                if (!ent_rd_en && !rd_vld_reg)
                begin
                    state_next = ST_FINISH;
                end
            end
            ST_FINISH:
            begin
                if (!rsp_valid_reg || rsp_ready)
                begin
                    rsp_next.out_of_range = oor_reg;
                    if (sre_reg[SW-1:31] != {(SW-31){sre_reg[SW-1]}})
                    begin
                        rsp_next.value_re = sre_reg[SW-1] ? csrel_pkg::SAT_MIN
                                                          : csrel_pkg::SAT_MAX;
                    end
                    else
                    begin
                        rsp_next.value_re = sre_reg[31:0];
                    end
                    if (sim_fin[SW-1:31] != {(SW-31){sim_fin[SW-1]}})
                    begin
                        rsp_next.value_im = sim_fin[SW-1] ? csrel_pkg::SAT_MIN
                                                          : csrel_pkg::SAT_MAX;
                    end
                    else
                    begin
                        rsp_next.value_im = sim_fin[31:0];
                    end
                    rsp_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            i0_reg        <= '0;
            j0_reg        <= '0;
            neg_reg       <= 1'b0;
            oor_reg       <= 1'b0;
            k_reg         <= '0;
            end_reg       <= '0;
            rd_vld_reg    <= 1'b0;
            sre_reg       <= '0;
            sim_reg       <= '0;
            rsp_reg       <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            i0_reg        <= i0_next;
            j0_reg        <= j0_next;
            neg_reg       <= neg_next;
            oor_reg       <= oor_next;
            k_reg         <= k_next;
            end_reg       <= end_next;
            rd_vld_reg    <= rd_vld_next;
            sre_reg       <= sre_next;
            sim_reg       <= sim_next;
            rsp_reg       <= rsp_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    a_oor_zero: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp.out_of_range |-> (rsp.value_re == 0) && (rsp.value_im == 0))
        else $error("out-of-range result carries a nonzero value");

    a_query_blocks: assert property (@(posedge clk) disable iff (!rst_n)
        accept && (req.operation == csrel_pkg::OP_QUERY) |=> !req_ready)
        else $error("new item taken while a query is in progress");

    a_scan_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_SCAN) && ent_rd_en |-> (k_reg < KW'(MAX_NNZ)))
        else $error("entry scan beyond the nonzero store");

    a_read_idle: assert property (@(posedge clk) disable iff (!rst_n)
        rd_vld_reg |-> $past(state_reg == ST_SCAN) && (state_reg == ST_SCAN))
        else $error("entry read data arrives outside the scan");

endmodule
`default_nettype wire

### test/csr_entry_lookup_unit_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// csr_entry_lookup_unit_tb
// Self-checking bench for the compressed-row element lookup unit. A full
// matrix is loaded once: every row start, every stored entry, and a top row
// whose end runs past the entry table, followed by an empty row with inverted
// bounds. Directed items then cover out-of-range indices, saturating sums
// and ignored items. Random phases run under a series of register settings,
// from all clear through all set and then random ones, mixing queries, entry
// and row reloads and ignored items. Every accepted item runs through a local
// predictor, and each result is compared against the oldest prediction. Both handshakes idle at random.
// ----------------------------------------------------------------------------
module csr_entry_lookup_unit_tb;
    import csrel_pkg::*;

    localparam int N_ROWS      = MAX_ROWS_DEF;
    localparam int N_NNZ       = MAX_NNZ_DEF;
    localparam logic [1:0] OP_UNUSED = 2'd3;
    localparam int N_PHASES    = 11;
    localparam int PHASE_ITEMS = 73;
    localparam int TOP_SLOT    = 4088;
    localparam int TOP_START   = 4090;
    localparam int TOP_END     = 4097;
    localparam int MAX_REPORTS = 10;

    logic              clk       = 1'b0;
    logic              rst_n     = 1'b0;
    logic              req_valid = 1'b0;
    logic              req_ready;
    req_t              req       = '0;
    logic              rsp_valid;
    logic              rsp_ready = 1'b0;
    rsp_t              rsp;
    logic              psel      = 1'b0;
    logic              penable   = 1'b0;
    logic              pwrite    = 1'b0;
    logic [CFG_AW-1:0] paddr     = '0;
    logic [CFG_DW-1:0] pwdata    = '0;
    logic [CFG_DW-1:0] prdata;
    logic              pready;

    csr_entry_lookup_unit uut
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .rsp       (rsp),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .prdata    (prdata),
        .pready    (pready)
    );

    cfg_t               model_cfg = '0;
    logic [RSW-1:0]     row_start_tab [0:N_ROWS];
    logic [COLW-1:0]    col_tab       [0:N_NNZ-1];
    logic signed [31:0] re_tab        [0:N_NNZ-1];
    logic signed [31:0] im_tab        [0:N_NNZ-1];

    int                 plan_row_start [0:N_ROWS];
    logic [COLW-1:0]    plan_col       [0:N_NNZ-1];
    int                 plan_base = 0;

    req_t queued_requests   [$];
    rsp_t expected_elements [$];

    logic req_taken    = 1'b0;
    int   tx_gap       = 0;
    int   tx_burst     = 0;
    int   rx_hold      = 0;
    int   rx_mode      = 0;
    int   rx_mode_left = 0;

    int bad_count  = 0;
    int n_results  = 0;
    int n_queued   = 0;
    int n_accepted = 0;
    int n_queries  = 0;
    int n_loads    = 0;
    int n_ignored  = 0;
    int n_settings = 0;

    initial
    begin
        forever #10 clk = ~clk;
    end

    initial
    begin
        #20_000_000;
        $display("FAIL csr_entry_lookup_unit");
        $finish;
    end

    function automatic logic signed [31:0] clamp_q(input longint v);
        if (v > 64'sd2147483647)
            return SAT_MAX;
        if (v < -64'sd2147483648)
            return SAT_MIN;
        return v[31:0];
    endfunction

    function automatic bit lookup_element(input req_t it, output rsp_t res);
        longint lo, hi, k, col, sum_re, sum_im;
        int     r, c, ri, ci;
        bit     mirrored;
        res      = '0;
        sum_re   = 0;
        sum_im   = 0;
        mirrored = 1'b0;
        case (it.operation)
            OP_LOAD_ROW:
            begin
                if (it.slot <= N_ROWS)
                    row_start_tab[it.slot] = it.row_start_value;
                return 1'b0;
            end
            OP_LOAD_ENTRY:
            begin
                col_tab[it.slot] = it.stored_column;
                re_tab[it.slot]  = it.load_re;
                im_tab[it.slot]  = it.load_im;
                return 1'b0;
            end
            OP_QUERY: ;
            default: return 1'b0;
        endcase
        r = it.query_row;
        c = it.query_col;
        if (r < 1 || r > N_ROWS || c < 1 || c > N_ROWS)
        begin
            res.out_of_range = 1'b1;
            return 1'b1;
        end
        if (r == c && model_cfg.unit_diag_implicit)
        begin
            res.value_re = Q_ONE;
            return 1'b1;
        end
        if (model_cfg.tri_upper && c < r)
            return 1'b1;
        if (model_cfg.tri_lower && c > r)
            return 1'b1;
        ri = r;
        ci = c;
        if ((model_cfg.symmetric || model_cfg.hermitian) &&
            (model_cfg.stored_upper != model_cfg.stored_lower) &&
            ((model_cfg.stored_upper && c < r) || (model_cfg.stored_lower && c > r)))
        begin
            mirrored = 1'b1;
            ri = c;
            ci = r;
        end
        lo = longint'(row_start_tab[ri-1]) - longint'(model_cfg.index_base);
        hi = longint'(row_start_tab[ri]) - longint'(model_cfg.index_base);
        if (lo < 0)
            lo = 0;
        if (hi > N_NNZ)
            hi = N_NNZ;
        for (k = lo; k < hi; k++)
        begin
            col = longint'(col_tab[k]) + 1 - longint'(model_cfg.index_base);
            if (col == ci)
            begin
                sum_re += longint'(re_tab[k]);
                sum_im += longint'(im_tab[k]);
            end
        end
        if (mirrored && model_cfg.hermitian && ri != ci)
            sum_im = -sum_im;
        res.value_re = clamp_q(sum_re);
        res.value_im = clamp_q(sum_im);
        return 1'b1;
    endfunction

    always @(negedge clk)
    begin
        if (rst_n && (!req_valid || req_taken))
        begin
            if (tx_gap > 0)
            begin
                tx_gap--;
                req_valid <= 1'b0;
            end
            else if (queued_requests.size() > 0)
            begin
                req       <= queued_requests.pop_front();
                req_valid <= 1'b1;
                if (tx_burst > 0)
                    tx_burst--;
                else
                begin
                    tx_burst = $urandom_range(1, 40);
                    tx_gap   = ($urandom_range(0, 3) == 0) ? $urandom_range(8, 24)
                                                           : $urandom_range(0, 5);
                end
            end
            else
                req_valid <= 1'b0;
        end
    end

    always @(negedge clk)
    begin
        if (rx_mode_left == 0)
        begin
            rx_mode      = $urandom_range(0, 2);
            rx_mode_left = $urandom_range(50, 400);
        end
        else
            rx_mode_left--;
        if (rx_hold > 0)
        begin
            rsp_ready <= 1'b0;
            rx_hold--;
        end
        else
        begin
            rsp_ready <= 1'b1;
            case (rx_mode)
                1: if ($urandom_range(0, 3) == 0) rx_hold = $urandom_range(1, 3);
                2: if ($urandom_range(0, 15) == 0) rx_hold = $urandom_range(4, 12);
                default: ;
            endcase
        end
    end

    always @(posedge clk)
    begin : monitor
        rsp_t want;
        rsp_t pred;
        if (!rst_n)
            req_taken <= 1'b0;
        else
        begin
            req_taken <= req_valid && req_ready;
            if (rsp_valid && rsp_ready)
            begin
                n_results++;
                if (expected_elements.size() == 0)
                begin
                    if (bad_count < MAX_REPORTS)
                        $display("unexpected result at %0t: re %h im %h oor %b",
                                 $realtime, rsp.value_re, rsp.value_im, rsp.out_of_range);
                    bad_count++;
                end
                else
                begin
                    want = expected_elements.pop_front();
                    if (rsp.value_re !== want.value_re || rsp.value_im !== want.value_im ||
                        rsp.out_of_range !== want.out_of_range)
                    begin
                        if (bad_count < MAX_REPORTS)
                            $display({"mismatch at %0t: expected re %h im %h oor %b,",
                                      " got re %h im %h oor %b"}, $realtime,
                                     want.value_re, want.value_im, want.out_of_range,
                                     rsp.value_re, rsp.value_im, rsp.out_of_range);
                        bad_count++;
                    end
                end
            end
            if (req_valid && req_ready)
            begin
                n_accepted++;
                if (lookup_element(req, pred))
                    expected_elements.push_back(pred);
            end
        end
    end

    function automatic req_t random_item();
        logic [127:0] raw;
        raw = {$urandom, $urandom, $urandom, $urandom};
        return raw[$bits(req_t)-1:0];
    endfunction

    function automatic logic [31:0] rand_q();
        case ($urandom_range(0, 7))
            0: return SAT_MAX;
            1: return SAT_MIN;
            2: return $urandom_range(0, 200000);
            3: return 0 - $urandom_range(1, 200000);
            default: return $urandom;
        endcase
    endfunction

    function automatic logic [COLW-1:0] pick_col(input int r);
        int j;
        if ($urandom_range(0, 7) == 0)
            return COLW'($urandom_range(0, 511));
        j = r + $urandom_range(0, 4) - 2;
        if (j < 1)
            j = 1;
        if (j > N_ROWS)
            j = N_ROWS;
        return COLW'(j - 1 + plan_base);
    endfunction

    task automatic enqueue(input req_t it);
        queued_requests.push_back(it);
        n_queued++;
    endtask

    task automatic push_row(input int slot, input int val);
        req_t it;
        it                 = random_item();
        it.operation       = OP_LOAD_ROW;
        it.slot            = SLOTW'(slot);
        it.row_start_value = RSW'(val);
        if (slot <= N_ROWS)
            n_loads++;
        else
            n_ignored++;
        enqueue(it);
    endtask

    task automatic push_entry(input int slot, input logic [COLW-1:0] col,
                              input logic [31:0] re, input logic [31:0] im);
        req_t it;
        it               = random_item();
        it.operation     = OP_LOAD_ENTRY;
        it.slot          = SLOTW'(slot);
        it.stored_column = col;
        it.load_re       = re;
        it.load_im       = im;
        plan_col[slot]   = col;
        n_loads++;
        enqueue(it);
    endtask

    task automatic push_query(input int r, input int c);
        req_t it;
        it           = random_item();
        it.operation = OP_QUERY;
        it.query_row = IDXW'(r);
        it.query_col = IDXW'(c);
        n_queries++;
        enqueue(it);
    endtask

    task automatic push_unused();
        req_t it;
        it           = random_item();
        it.operation = OP_UNUSED;
        n_ignored++;
        enqueue(it);
    endtask

    task automatic pick_query();
        int r, c, t, lo, hi, sel;
        sel = $urandom_range(0, 9);
        if (sel == 0)
        begin
            r = $urandom_range(0, 511);
            c = $urandom_range(0, 511);
            if (r >= 1 && r <= N_ROWS && c >= 1 && c <= N_ROWS)
            begin
                if ($urandom_range(0, 1))
                    r = $urandom_range(0, 1) ? 0 : $urandom_range(N_ROWS + 1, 511);
                else
                    c = $urandom_range(0, 1) ? 0 : $urandom_range(N_ROWS + 1, 511);
            end
        end
        else if (sel == 1)
        begin
            r = $urandom_range(1, N_ROWS);
            c = r;
        end
        else
        begin
            if (sel == 2)
                r = $urandom_range(0, 1) ? $urandom_range(1, 3) : 40 * $urandom_range(1, 6);
            else
                r = $urandom_range(1, N_ROWS);
            lo = plan_row_start[r-1] - plan_base;
            hi = plan_row_start[r] - plan_base;
            if (lo < 0)
                lo = 0;
            if (hi > N_NNZ)
                hi = N_NNZ;
            if (lo < hi && $urandom_range(0, 4) != 0)
            begin
                c = plan_col[$urandom_range(lo, hi - 1)] + 1 - plan_base;
                if (c < 1 || c > N_ROWS)
                    c = $urandom_range(1, N_ROWS);
            end
            else
            begin
                c = r + $urandom_range(0, 6) - 3;
                if (c < 1)
                    c = 1;
                if (c > N_ROWS)
                    c = N_ROWS;
            end
            if ($urandom_range(0, 2) == 0)
            begin
                t = r;
                r = c;
                c = t;
            end
        end
        push_query(r, c);
    endtask

    task automatic build_matrix();
        int r, k, len;
        plan_row_start[0] = TOP_START;
        plan_row_start[1] = TOP_END;
        plan_row_start[2] = 0;
        for (r = 3; r <= N_ROWS; r++)
        begin
            len = (r % 40 == 0) ? $urandom_range(10, 20) : $urandom_range(0, 3);
            plan_row_start[r] = plan_row_start[r-1] + len;
        end
        for (r = 0; r <= N_ROWS; r++)
            push_row(r, plan_row_start[r]);
        for (r = 3; r <= N_ROWS; r++)
            for (k = plan_row_start[r-1]; k < plan_row_start[r]; k++)
                push_entry(k, pick_col(r), rand_q(), rand_q());
        for (k = TOP_SLOT; k < N_NNZ; k++)
            push_entry(k, pick_col(1), rand_q(), rand_q());
    endtask

    task automatic directed_part();
        push_query(0, 5);
        push_query(7, 0);
        push_query(N_ROWS + 1, 1);
        push_query(1, N_ROWS + 1);
        push_query(511, 511);
        push_query(N_ROWS, N_ROWS);
        push_query(1, 1);
        // saturate both parts in the clamped top row
        push_entry(N_NNZ - 2, COLW'(9), SAT_MAX, SAT_MIN);
        push_entry(N_NNZ - 1, COLW'(9), SAT_MAX, SAT_MIN);
        push_query(1, 10);
        // pull the exact real sum back inside the range; the imaginary one stays below it
        push_entry(N_NNZ - 3, COLW'(9), SAT_MIN, SAT_MAX);
        push_query(1, 10);
        push_query(2, 2);
        push_query(2, 5);
        push_query(3, 3);
        push_unused();
        push_row(4095, 8191);
        push_row(N_ROWS + 1, 0);
        push_row(N_ROWS, plan_row_start[N_ROWS]);
        push_query(N_ROWS, N_ROWS - 1);
        push_query(N_ROWS - 1, N_ROWS);
    endtask

    task automatic random_phase(input int n);
        int i, sel, r, slot;
        for (i = 0; i < n; i++)
        begin
            sel = $urandom_range(0, 19);
            if (sel < 12)
                pick_query();
            else if (sel < 17)
            begin
                r = $urandom_range(3, N_ROWS);
                if (plan_row_start[r] > plan_row_start[r-1])
                    slot = $urandom_range(plan_row_start[r-1], plan_row_start[r] - 1);
                else
                begin
                    r    = 1;
                    slot = $urandom_range(TOP_SLOT, N_NNZ - 1);
                end
                push_entry(slot, pick_col(r), rand_q(), rand_q());
            end
            else if (sel == 17)
            begin
                slot = $urandom_range(0, N_ROWS);
                push_row(slot, plan_row_start[slot]);
            end
            else if (sel == 18)
                push_unused();
            else
                push_row($urandom_range(N_ROWS + 1, 4095), $urandom_range(0, 8191));
        end
    endtask

    function automatic cfg_t phase_setting(input int p);
        cfg_t       c;
        logic [7:0] bits;
        c = '0;
        case (p)
            1: c.index_base = 1'b1;
            2:
            begin
                c.unit_diag_implicit = 1'b1;
                c.tri_upper          = 1'b1;
            end
            3:
            begin
                c.tri_lower  = 1'b1;
                c.index_base = 1'b1;
            end
            4:
            begin
                c.symmetric    = 1'b1;
                c.stored_upper = 1'b1;
            end
            5:
            begin
                c.hermitian    = 1'b1;
                c.stored_lower = 1'b1;
                c.index_base   = 1'b1;
            end
            6:
            begin
                c.hermitian          = 1'b1;
                c.stored_upper       = 1'b1;
                c.unit_diag_implicit = 1'b1;
            end
            7: c = '1;
            default:
            begin
                bits = 8'($urandom_range(0, 255));
                c    = bits;
            end
        endcase
        return c;
    endfunction

    task automatic apb_write(input logic [2:0] idx, input logic v);
        @(negedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= {31'b0, v};
        @(negedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic write_cfg(input cfg_t c);
        apb_write(REG_INDEX_BASE, c.index_base);
        apb_write(REG_UNIT_DIAG, c.unit_diag_implicit);
        apb_write(REG_TRI_UPPER, c.tri_upper);
        apb_write(REG_TRI_LOWER, c.tri_lower);
        apb_write(REG_SYMMETRIC, c.symmetric);
        apb_write(REG_HERMITIAN, c.hermitian);
        apb_write(REG_STORED_UPPER, c.stored_upper);
        apb_write(REG_STORED_LOWER, c.stored_lower);
        model_cfg = c;
        plan_base = c.index_base;
        n_settings++;
    endtask

    task automatic settle(input int tail);
        while (n_accepted != n_queued || expected_elements.size() != 0)
            @(negedge clk);
        repeat (tail) @(negedge clk);
    endtask

    initial
    begin : main
        int p;
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        write_cfg(phase_setting(0));
        build_matrix();
        directed_part();
        random_phase(PHASE_ITEMS);
        for (p = 1; p < N_PHASES; p++)
        begin
            settle(8);
            write_cfg(phase_setting(p));
            random_phase(PHASE_ITEMS);
        end
        settle(64);
        $display("covered %0d queries, %0d table loads, %0d ignored items, %0d settings",
                 n_queries, n_loads, n_ignored, n_settings);
        $display("compared %0d results, %0d mismatches", n_results, bad_count);
        if (bad_count == 0)
            $display("PASS csr_entry_lookup_unit");
        else
            $display("FAIL csr_entry_lookup_unit");
        $finish;
    end

endmodule
